// ----- rtl/core/erc_pkg.sv -----
`default_nettype none

package erc_pkg;

  localparam int unsigned CountW = 6;
  localparam int unsigned CfgIndexW = 2;

  localparam int unsigned BodyLen = 32;
  localparam logic [CountW-1:0] RecLen = 6'd36;
  localparam logic [CountW-1:0] CountCap = 6'd37;
  localparam logic [CountW-1:0] LastPos = 6'd35;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  localparam logic [CfgIndexW-1:0] RegMagic = 2'd0;
  localparam logic [CfgIndexW-1:0] RegVersion = 2'd1;

  localparam logic [31:0] MagicReset = 32'h0000_0000;
  localparam logic [7:0] VersionReset = 8'h01;

  typedef enum logic [2:0] {
    StatusOk = 3'd0,
    StatusBadSize = 3'd1,
    StatusBadMagic = 3'd2,
    StatusBadVersion = 3'd3,
    StatusBadCrc = 3'd4
  } status_e;

  // Packed so that the last field (status) lands in the lowest bits of tdata.
  typedef struct packed {
    logic [4:0] pad;
    logic [31:0] detail_word;
    logic [15:0] anomaly_score;
    logic [15:0] current_ma;
    logic [15:0] vibration;
    logic signed [15:0] temperature;
    logic [15:0] snapshot_flags;
    logic [7:0] record_flags;
    logic [7:0] machine_state;
    logic [31:0] time_ms;
    logic [31:0] sequence_num;
    logic [23:0] event_kind;
    status_e status;
  } result_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/event_record_checker_decoder.sv -----
// A record's result is registered into the output stage when its last byte is taken.
// One byte per cycle while s_axis_tready is high; CRC update and byte capture finish on accept.
// A two-entry output stage (result register plus skid register) keeps bytes flowing while a
// result waits; s_axis_tready drops only when both entries are full.
// Reset (rst_ni low, asynchronous): byte count zero, CRC all ones, output empty, magic_word 0,
// format_version 1. The byte store is not reset; only bytes of the current record are read.
`default_nettype none

module event_record_checker_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration write channel.
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [erc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // Byte stream in.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rec_byte[7:0]
  input  wire logic         s_axis_tlast,   // last_byte
  // Result stream out.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], event_kind[26:3], sequence_num[58:27], time_ms[90:59],
  // machine_state[98:91], record_flags[106:99], snapshot_flags[122:107],
  // temperature[138:123], vibration[154:139], current_ma[170:155],
  // anomaly_score[186:171], detail_word[218:187], zero pad[223:219]
  output logic [223:0]      m_axis_tdata
);

  logic [31:0] magic_q;
  logic [7:0]  version_q;

  logic [erc_pkg::CountW-1:0] count_q;
  logic [31:0] crc_q;
  logic [31:0] rcv_crc_q;
  logic [7:0]  store_q [erc_pkg::BodyLen];

  erc_pkg::result_t out_q, skid_q, res_d;
  logic out_valid_q, skid_valid_q;

  logic in_acc, push, pop;
  logic [erc_pkg::CountW-1:0] count_next;
  logic [31:0] crc_final;
  logic [31:0] rcv_full;
  logic [31:0] magic_rx;
  erc_pkg::status_e status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= erc_pkg::MagicReset;
      version_q <= erc_pkg::VersionReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        erc_pkg::RegMagic:   magic_q <= cfg_data_i;
        erc_pkg::RegVersion: version_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign push = in_acc && s_axis_tlast;
  assign pop = out_valid_q && m_axis_tready;

  // Count saturates at one past the record length so long records stay bad size.
  assign count_next = (count_q != erc_pkg::CountCap) ? count_q + 6'd1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q <= erc_pkg::CrcOnes;
      rcv_crc_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        count_q <= '0;
        crc_q <= erc_pkg::CrcOnes;
        rcv_crc_q <= '0;
      end else begin
        count_q <= count_next;
        if (!count_q[5]) begin
          crc_q <= erc_pkg::crc32_byte(crc_q, s_axis_tdata);
        end else if (count_q < erc_pkg::RecLen) begin
          case (count_q[1:0])
            2'd0: rcv_crc_q[7:0] <= s_axis_tdata;
            2'd1: rcv_crc_q[15:8] <= s_axis_tdata;
            2'd2: rcv_crc_q[23:16] <= s_axis_tdata;
            default: rcv_crc_q[31:24] <= s_axis_tdata;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !count_q[5]) begin
      store_q[count_q[4:0]] <= s_axis_tdata;
    end
  end

  // A record of the right length ends at the byte that completes the received CRC, and the
  // body CRC is already final at that point.
  assign rcv_full = {s_axis_tdata, rcv_crc_q[23:0]};
  assign crc_final = crc_q ^ erc_pkg::CrcOnes;
  assign magic_rx = {store_q[3], store_q[2], store_q[1], store_q[0]};

  always_comb begin
    if (count_q != erc_pkg::LastPos) begin
      status = erc_pkg::StatusBadSize;
    end else if (magic_rx != magic_q) begin
      status = erc_pkg::StatusBadMagic;
    end else if (store_q[4] != version_q) begin
      status = erc_pkg::StatusBadVersion;
    end else if (crc_final != rcv_full) begin
      status = erc_pkg::StatusBadCrc;
    end else begin
      status = erc_pkg::StatusOk;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.status = status;
    if (status == erc_pkg::StatusOk) begin
      res_d.event_kind = {store_q[7], store_q[6], store_q[5]};
      res_d.sequence_num = {store_q[11], store_q[10], store_q[9], store_q[8]};
      res_d.time_ms = {store_q[15], store_q[14], store_q[13], store_q[12]};
      res_d.machine_state = store_q[16];
      res_d.record_flags = store_q[17];
      res_d.snapshot_flags = {store_q[19], store_q[18]};
      res_d.temperature = {store_q[21], store_q[20]};
      res_d.vibration = {store_q[23], store_q[22]};
      res_d.current_ma = {store_q[25], store_q[24]};
      res_d.anomaly_score = {store_q[27], store_q[26]};
      res_d.detail_word = {store_q[31], store_q[30], store_q[29], store_q[28]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register is empty");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tlast && count_q != erc_pkg::CountCap)
      |=> count_q == $past(count_q) + 6'd1)
    else $error("byte count did not advance");

  a_record_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (count_q == '0 && crc_q == erc_pkg::CrcOnes && rcv_crc_q == '0))
    else $error("record state not cleared after last byte");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != erc_pkg::StatusOk)
      |-> (out_q.sequence_num == '0 && out_q.detail_word == '0 && out_q.event_kind == '0))
    else $error("failed record carries nonzero fields");

  a_result_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> out_valid_q)
    else $error("result not presented one cycle after last byte");

endmodule

`default_nettype wire
